// ===== design/t2crb_pkg.sv =====
package t2crb_pkg;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_COUNT = 3'b010,
    ST_DONE  = 3'b100
  } seq_state_e;

  typedef enum logic [2:0] {
    MODE_RELOAD  = 3'd0,
    MODE_CAPTURE = 3'd1,
    MODE_BAUD    = 3'd2,
    MODE_DOWN    = 3'd3,
    MODE_CLKOUT  = 3'd4
  } timer_mode_e;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_PINS  = 2'd3
  } func_e;

  localparam logic [2:0] REG_CONTROL     = 3'd0;
  localparam logic [2:0] REG_MODE        = 3'd1;
  localparam logic [2:0] REG_COUNT_LOW   = 3'd2;
  localparam logic [2:0] REG_COUNT_HIGH  = 3'd3;
  localparam logic [2:0] REG_RELOAD_LOW  = 3'd4;
  localparam logic [2:0] REG_RELOAD_HIGH = 3'd5;

  localparam logic [1:0] CFG_DOWN_COUNT_EN = 2'd0;
  localparam logic [1:0] CFG_CLOCK_OUT_EN  = 2'd1;

  // Control register bit positions.
  localparam int unsigned B_TF2   = 7;
  localparam int unsigned B_EXF2  = 6;
  localparam int unsigned B_RCLK  = 5;
  localparam int unsigned B_TCLK  = 4;
  localparam int unsigned B_EXEN2 = 3;
  localparam int unsigned B_TR2   = 2;
  localparam int unsigned B_CT2   = 1;
  localparam int unsigned B_CPRL2 = 0;

  localparam logic [3:0] EDGE_MAX   = 4'd15;
  localparam logic [2:0] CYCLES_MAX = 3'd4;

  // Step width: up to four machine cycles at six increments each.
  localparam int unsigned STEP_W = 5;

  typedef struct packed {
    logic down;
    logic reload_en;
  } step_ctrl_t;

  function automatic timer_mode_e pick_mode(logic [7:0] ctrl, logic [1:0] mode_reg,
                                            logic dcen_en, logic clkout_en);
    timer_mode_e m;
    if (clkout_en && mode_reg[1]) begin
      m = MODE_CLKOUT;
    end else if (ctrl[B_RCLK] || ctrl[B_TCLK]) begin
      m = MODE_BAUD;
    end else if (ctrl[B_CPRL2]) begin
      m = MODE_CAPTURE;
    end else if (dcen_en && mode_reg[0]) begin
      m = MODE_DOWN;
    end else begin
      m = MODE_RELOAD;
    end
    return m;
  endfunction

endpackage

// ===== design/timer2_capture_reload_baud.sv =====
// Channel   Direction  Handshake             Payload
// --------  ---------  --------------------  ------------------------------------------
// in        sink       in_valid_i/in_stall_o  func, reg_select, write_data, cycles, pins
// out       source     out_valid_o/out_stall_i read_data, flags, irq, baud_overflows, T2
// cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A register write, read or pin sample goes from accept straight to the done state.
// A tick with TR2 set first runs the count state for n increments (up to 24), as
// the shared 16-bit step unit advances the count once a cycle, then goes to done.
// Reset is asynchronous and active low; it restores all control and timer state.
// The input is stalled while a beat is being worked on; a finished result waits
// in the output register, and a new beat may be accepted while it waits.
module timer2_capture_reload_baud
  import t2crb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [2:0] reg_select_i,
  input  logic [7:0] write_data_i,
  input  logic [2:0] machine_cycles_i,
  input  logic       t_pin_i,
  input  logic       t2ex_pin_i,

  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       overflow_flag_o,
  output logic       external_flag_o,
  output logic       irq_request_o,
  output logic [4:0] baud_overflows_o,
  output logic       clock_out_level_o,

  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic       cfg_data_i
);

  seq_state_e  state_q, state_d;
  timer_mode_e mode_q, mode_d, mode_new;

  logic [15:0] count_q, count_d;
  logic [15:0] reload_q, reload_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [1:0]  mreg_q, mreg_d;
  logic        dcen_q, dcen_d;
  logic        coen_q, coen_d;
  logic [3:0]  t_edges_q, t_edges_d;
  logic [3:0]  x_edges_q, x_edges_d;
  logic [1:0]  prev_pins_q, prev_pins_d;
  logic        clk_out_q, clk_out_d;

  logic [STEP_W-1:0] steps_q, steps_d;
  logic [STEP_W-1:0] ovs_q, ovs_d;
  logic [7:0]        rd_q, rd_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  o_rd_q, o_rd_d;
  logic        o_tf2_q, o_tf2_d;
  logic        o_exf2_q, o_exf2_d;
  logic        o_irq_q, o_irq_d;
  logic [4:0]  o_bov_q, o_bov_d;
  logic        o_clk_q, o_clk_d;

  logic        in_fire;
  logic        out_free;
  logic [2:0]  cyc_capped;
  logic [STEP_W-1:0] cyc_scaled;
  logic        fast_mode;
  step_ctrl_t  step_ctrl;
  logic [15:0] step_next;
  logic        step_event;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Baud and clock-out modes count six increments per machine cycle.
  assign fast_mode  = (mode_q == MODE_BAUD) || (mode_q == MODE_CLKOUT);
  assign cyc_capped = (machine_cycles_i > CYCLES_MAX) ? CYCLES_MAX : machine_cycles_i;
  assign cyc_scaled = fast_mode ? ({2'b00, cyc_capped} << 2) + ({2'b00, cyc_capped} << 1)
                                : {2'b00, cyc_capped};

  // Down counting follows the T2EX level seen at the last pin sample.
  assign step_ctrl.down      = (mode_q == MODE_DOWN) && !prev_pins_q[1];
  assign step_ctrl.reload_en = (mode_q != MODE_CAPTURE);

  t2crb_step_unit u_step (
    .count_i  (count_q),
    .reload_i (reload_q),
    .ctrl_i   (step_ctrl),
    .next_o   (step_next),
    .event_o  (step_event)
  );

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    count_d     = count_q;
    reload_d    = reload_q;
    ctrl_d      = ctrl_q;
    mreg_d      = mreg_q;
    dcen_d      = dcen_q;
    coen_d      = coen_q;
    t_edges_d   = t_edges_q;
    x_edges_d   = x_edges_q;
    prev_pins_d = prev_pins_q;
    clk_out_d   = clk_out_q;
    steps_d     = steps_q;
    ovs_d       = ovs_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q;
    o_rd_d      = o_rd_q;
    o_tf2_d     = o_tf2_q;
    o_exf2_d    = o_exf2_q;
    o_irq_d     = o_irq_q;
    o_bov_d     = o_bov_q;
    o_clk_d     = o_clk_q;
    mode_new    = mode_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // The user must send configuration beats only while the block is idle; the block itself does not enforce this.
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_DOWN_COUNT_EN) begin
        dcen_d = cfg_data_i;
      end else if (cfg_index_i == CFG_CLOCK_OUT_EN) begin
        coen_d = cfg_data_i;
      end
      mode_new = pick_mode(ctrl_q, mreg_q, dcen_d, coen_d);
      mode_d   = mode_new;
      if (mode_new != mode_q) begin
        t_edges_d = '0;
        x_edges_d = '0;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rd_d    = 8'h00;
          ovs_d   = '0;
          state_d = ST_DONE;
          case (func_i)
            FUNC_TICK: begin
              // A pending T2EX edge acts first, whether or not the timer runs.
              if (mode_q != MODE_DOWN && ctrl_q[B_EXEN2] && (x_edges_q != 4'd0)) begin
                ctrl_d[B_EXF2] = 1'b1;
                x_edges_d      = '0;
                if (mode_q == MODE_CAPTURE) begin
                  reload_d = count_q;
                end else if (mode_q == MODE_RELOAD) begin
                  count_d = reload_q;
                end
              end
              if (ctrl_q[B_TR2]) begin
                if (ctrl_q[B_CT2]) begin
                  steps_d   = {1'b0, t_edges_q};
                  t_edges_d = '0;
                end else begin
                  steps_d = cyc_scaled;
                end
                state_d = ST_COUNT;
              end
            end
            FUNC_WRITE: begin
              case (reg_select_i)
                REG_CONTROL: begin
                  ctrl_d   = write_data_i;
                  mode_new = pick_mode(write_data_i, mreg_q, dcen_q, coen_q);
                  mode_d   = mode_new;
                  if (mode_new != mode_q || write_data_i[B_TR2] != ctrl_q[B_TR2]) begin
                    t_edges_d = '0;
                    x_edges_d = '0;
                  end
                end
                REG_MODE: begin
                  mreg_d   = write_data_i[1:0];
                  mode_new = pick_mode(ctrl_q, write_data_i[1:0], dcen_q, coen_q);
                  mode_d   = mode_new;
                  if (mode_new != mode_q) begin
                    t_edges_d = '0;
                    x_edges_d = '0;
                  end
                end
                REG_COUNT_LOW:   count_d[7:0]   = write_data_i;
                REG_COUNT_HIGH:  count_d[15:8]  = write_data_i;
                REG_RELOAD_LOW:  reload_d[7:0]  = write_data_i;
                REG_RELOAD_HIGH: reload_d[15:8] = write_data_i;
                default: ;
              endcase
            end
            FUNC_READ: begin
              case (reg_select_i)
                REG_CONTROL:     rd_d = ctrl_q;
                REG_MODE:        rd_d = {6'd0, mreg_q};
                REG_COUNT_LOW:   rd_d = count_q[7:0];
                REG_COUNT_HIGH:  rd_d = count_q[15:8];
                REG_RELOAD_LOW:  rd_d = reload_q[7:0];
                REG_RELOAD_HIGH: rd_d = reload_q[15:8];
                default:         rd_d = 8'h00;
              endcase
            end
            default: begin
              // Pin sample: count falling edges, saturating.
              if (prev_pins_q[0] && !t_pin_i && t_edges_q < EDGE_MAX) begin
                t_edges_d = t_edges_q + 4'd1;
              end
              if (prev_pins_q[1] && !t2ex_pin_i && x_edges_q < EDGE_MAX) begin
                x_edges_d = x_edges_q + 4'd1;
              end
              prev_pins_d = {t2ex_pin_i, t_pin_i};
            end
          endcase
        end
      end

      ST_COUNT: begin
        if (steps_q != '0) begin
          count_d = step_next;
          ovs_d   = ovs_q + {{(STEP_W-1){1'b0}}, step_event};
          steps_d = steps_q - {{(STEP_W-1){1'b0}}, 1'b1};
        end else begin
          state_d = ST_DONE;
          case (mode_q)
            MODE_BAUD: ;
            MODE_CLKOUT: begin
              if (!ctrl_q[B_CT2] && ovs_q[0]) begin
                clk_out_d = !clk_out_q;
              end
            end
            MODE_DOWN: begin
              if (ovs_q != '0) begin
                ctrl_d[B_TF2] = 1'b1;
                if (ovs_q[0]) begin
                  ctrl_d[B_EXF2] = !ctrl_q[B_EXF2];
                end
              end
            end
            default: begin
              if (ovs_q != '0) begin
                ctrl_d[B_TF2] = 1'b1;
              end
            end
          endcase
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_rd_d      = rd_q;
          o_tf2_d     = ctrl_q[B_TF2];
          o_exf2_d    = ctrl_q[B_EXF2];
          o_irq_d     = ctrl_q[B_TF2] || (ctrl_q[B_EXF2] && mode_q != MODE_DOWN);
          o_bov_d     = fast_mode ? ovs_q : 5'd0;
          o_clk_d     = clk_out_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_RELOAD;
      count_q     <= '0;
      reload_q    <= '0;
      ctrl_q      <= '0;
      mreg_q      <= '0;
      dcen_q      <= 1'b0;
      coen_q      <= 1'b0;
      t_edges_q   <= '0;
      x_edges_q   <= '0;
      prev_pins_q <= 2'b11;
      clk_out_q   <= 1'b0;
      steps_q     <= '0;
      ovs_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      reload_q    <= reload_d;
      ctrl_q      <= ctrl_d;
      mreg_q      <= mreg_d;
      dcen_q      <= dcen_d;
      coen_q      <= coen_d;
      t_edges_q   <= t_edges_d;
      x_edges_q   <= x_edges_d;
      prev_pins_q <= prev_pins_d;
      clk_out_q   <= clk_out_d;
      steps_q     <= steps_d;
      ovs_q       <= ovs_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    rd_q     <= rd_d;
    o_rd_q   <= o_rd_d;
    o_tf2_q  <= o_tf2_d;
    o_exf2_q <= o_exf2_d;
    o_irq_q  <= o_irq_d;
    o_bov_q  <= o_bov_d;
    o_clk_q  <= o_clk_d;
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = o_rd_q;
  assign overflow_flag_o   = o_tf2_q;
  assign external_flag_o   = o_exf2_q;
  assign irq_request_o     = o_irq_q;
  assign baud_overflows_o  = o_bov_q;
  assign clock_out_level_o = o_clk_q;

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COUNT |-> steps_q <= 5'd24)
    else $error("step count exceeds the largest tick");

  a_bov_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> baud_overflows_o <= 5'd24)
    else $error("baud overflow count out of range");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != ST_IDLE)
    else $error("accepted beat did not start work");

  a_irq_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && irq_request_o |-> overflow_flag_o || external_flag_o)
    else $error("interrupt request without a flag");
`endif

endmodule

// ===== design/t2crb_step_unit.sv =====
module t2crb_step_unit
  import t2crb_pkg::*;
(
  input  logic [15:0] count_i,
  input  logic [15:0] reload_i,
  input  step_ctrl_t  ctrl_i,
  output logic [15:0] next_o,
  output logic        event_o
);

  logic [15:0] sum;
  logic        hit;

  // One adder serves both directions: plus one or minus one.
  assign sum = count_i + (ctrl_i.down ? 16'hffff : 16'h0001);
  assign hit = ctrl_i.down ? (count_i == reload_i) : (sum == 16'h0000);

  always_comb begin
    next_o  = sum;
    event_o = hit;
    if (hit) begin
      if (ctrl_i.down) begin
        next_o = 16'hffff;
      end else if (ctrl_i.reload_en) begin
        next_o = reload_i;
      end else begin
        next_o = 16'h0000;
      end
    end
  end

endmodule
